@@ design/oul_pkg.sv @@
// Package for the ordered unique ID list: sizes, command and status codes,
// controller states and the structs passed between the cells, scanner and top.
// No dependencies.
package oul_pkg;

	localparam int MAX_ENTRIES = 32;
	localparam int IDX_W       = $clog2(MAX_ENTRIES);
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
	localparam int ID_W        = 32;
	localparam int OCNT_W      = 6;
	localparam int IN_W        = 40;
	localparam int OUT_W       = 48;

	typedef enum logic [1:0] {
		CMD_ADD    = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_NEXT   = 2'd2,
		CMD_PREV   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_DONE    = 3'd0,
		ST_PRESENT = 3'd1,
		ST_ABSENT  = 3'd2,
		ST_FULL    = 3'd3,
		ST_EMPTY   = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE   = 2'd0,
		S_SCAN   = 2'd1,
		S_COMMIT = 2'd2
	} state_t;

	typedef struct packed {
		logic rot;
		logic take_next;
		logic load;
	} cell_ctl_t;

	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] pos;
		logic [ID_W-1:0]  prior;
		logic             has_after;
		logic [ID_W-1:0]  after;
		logic [ID_W-1:0]  first;
		logic [ID_W-1:0]  last;
	} scan_res_t;

endpackage

@@ design/oul_cell.sv @@
// One storage cell of the ID ring: holds one entry and takes its neighbor's
// value on rotate or gap close, or the new ID on append. Uses oul_pkg.
module oul_cell (
	input  logic                     clk,
	input  oul_pkg::cell_ctl_t       ctl,
	input  logic [oul_pkg::ID_W-1:0] nbr,
	input  logic [oul_pkg::ID_W-1:0] load_val,
	output logic [oul_pkg::ID_W-1:0] entry
);
	import oul_pkg::*;

	logic [ID_W-1:0] entry_q;

	always_ff @(posedge clk) begin
		if (ctl.rot || ctl.take_next) begin
			entry_q <= nbr;
		end else if (ctl.load) begin
			entry_q <= load_val;
		end
	end

	assign entry = entry_q;

endmodule

@@ design/oul_scan.sv @@
// Head scanner: watches the entry at the head of the rotating ring once per
// step and records match position, neighbors, first and last entries. Uses oul_pkg.
module oul_scan (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      clear,
	input  logic                      step,
	input  logic [oul_pkg::IDX_W-1:0] t,
	input  logic [oul_pkg::CNT_W-1:0] cnt,
	input  logic [oul_pkg::ID_W-1:0]  head,
	input  logic [oul_pkg::ID_W-1:0]  id,
	output oul_pkg::scan_res_t        res
);
	import oul_pkg::*;

	logic             found_q;
	logic             need_next_q;
	logic             has_after_q;
	logic [IDX_W-1:0] pos_q;
	logic [ID_W-1:0]  prev_q;
	logic [ID_W-1:0]  prior_q;
	logic [ID_W-1:0]  after_q;
	logic [ID_W-1:0]  first_q;
	logic [ID_W-1:0]  last_q;
	logic             valid_w;
	logic             is_last_w;

	assign valid_w   = CNT_W'(t) < cnt;
	assign is_last_w = (CNT_W'(t) + CNT_W'(1)) == cnt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q     <= 1'b0;
			need_next_q <= 1'b0;
			has_after_q <= 1'b0;
		end else if (clear) begin
			found_q     <= 1'b0;
			need_next_q <= 1'b0;
			has_after_q <= 1'b0;
		end else if (step && valid_w) begin
			if (!found_q && head == id) begin
				found_q     <= 1'b1;
				need_next_q <= 1'b1;
			end else if (need_next_q) begin
				has_after_q <= 1'b1;
				need_next_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			prev_q <= head;
			if (t == '0) begin
				first_q <= head;
			end
			if (valid_w && is_last_w) begin
				last_q <= head;
			end
			if (valid_w && !found_q && head == id) begin
				pos_q   <= t;
				prior_q <= prev_q;
			end else if (valid_w && need_next_q) begin
				after_q <= head;
			end
		end
	end

	always_comb begin
		res.found     = found_q;
		res.pos       = pos_q;
		res.prior     = prior_q;
		res.has_after = has_after_q;
		res.after     = after_q;
		res.first     = first_q;
		res.last      = last_q;
	end

`ifndef SYNTH
	a_after_needs_match: assert property (@(posedge clk) disable iff (!arst_n)
		has_after_q |-> found_q)
		else $error("neighbor captured without a match");
	a_pend_clears: assert property (@(posedge clk) disable iff (!arst_n)
		clear |=> !found_q && !has_after_q && !need_next_q)
		else $error("scanner not cleared at start");
	a_one_pending: assert property (@(posedge clk) disable iff (!arst_n)
		need_next_q |-> !has_after_q)
		else $error("next pending after capture");
`endif

endmodule

@@ design/ordered_unique_id_list.sv @@
// Ordered list of distinct 32-bit IDs kept in insertion order.
// Input stream (s_*): one transfer carries a command and an ID; output
// stream (m_*): one transfer per command with neighbor ID, status and count.
// Each command rotates the ring of MAX_ENTRIES cells once past the head
// scanner, then commits: append at the tail, gap close on remove, or
// neighbor select for next/prev.
// A new command is accepted only once the previous one has committed.
// s_tready is high while idle, also while a finished result waits on m_*.
// If the receiver stalls, the next command runs its scan and then holds in
// commit, with no list change, until the output register is free.
// Reset empties the list (count zero) and drops any pending result; cell
// contents are not cleared and are read only after being written.
// Commands: add, remove, next neighbor, previous neighbor. Statuses: done,
// already present, not present, full, empty.
module ordered_unique_id_list (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [oul_pkg::IN_W-1:0]  s_tdata,  // cmd[1:0], window_id[33:2], zero pad
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [oul_pkg::OUT_W-1:0] m_tdata   // neighbor_id[31:0], status[34:32],
	                                            // entry_count[40:35], zero pad
);
	import oul_pkg::*;

	state_t           state_q;
	state_t           state_d;
	logic [IDX_W-1:0] t_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_d;
	logic             m_tvalid_q;
	cmd_t             cmd_q;
	logic [ID_W-1:0]  id_q;
	logic [ID_W-1:0]  nbr_q;
	status_t          status_q;
	logic [OCNT_W-1:0] ocnt_q;

	logic             start;
	logic             out_free;
	logic             commit;
	logic             do_add;
	logic             do_rm;
	status_t          res_status;
	logic [ID_W-1:0]  res_nbr;
	scan_res_t        scan;

	cell_ctl_t        ctl   [MAX_ENTRIES];
	logic [ID_W-1:0]  entry [MAX_ENTRIES];

	assign s_tready = (state_q == S_IDLE);
	assign start    = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign commit   = (state_q == S_COMMIT) && out_free;

	always_comb begin
		res_status = ST_DONE;
		res_nbr    = '0;
		do_add     = 1'b0;
		do_rm      = 1'b0;
		cnt_d      = cnt_q;
		case (cmd_q)
			CMD_ADD: begin
				if (scan.found) begin
					res_status = ST_PRESENT;
				end else if (cnt_q == CNT_W'(MAX_ENTRIES)) begin
					res_status = ST_FULL;
				end else begin
					do_add = commit;
					cnt_d  = cnt_q + CNT_W'(1);
				end
			end
			CMD_REMOVE: begin
				if (scan.found) begin
					do_rm = commit;
					cnt_d = cnt_q - CNT_W'(1);
				end else begin
					res_status = ST_ABSENT;
				end
			end
			CMD_NEXT: begin
				if (cnt_q == '0) begin
					res_status = ST_EMPTY;
				end else begin
					res_status = scan.found ? ST_DONE : ST_ABSENT;
					res_nbr    = scan.has_after ? scan.after : scan.first;
				end
			end
			CMD_PREV: begin
				if (cnt_q == '0) begin
					res_status = ST_EMPTY;
				end else begin
					res_status = scan.found ? ST_DONE : ST_ABSENT;
					res_nbr    = (scan.found && scan.pos != '0) ? scan.prior : scan.last;
				end
			end
			default: begin
				res_status = ST_DONE;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (t_q == IDX_W'(MAX_ENTRIES - 1)) begin
					state_d = S_COMMIT;
				end
			end
			S_COMMIT: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			t_q        <= '0;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (start) begin
				t_q <= '0;
			end else if (state_q == S_SCAN) begin
				t_q <= t_q + IDX_W'(1);
			end
			if (commit) begin
				cnt_q      <= cnt_d;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			cmd_q <= cmd_t'(s_tdata[1:0]);
			id_q  <= s_tdata[33:2];
		end
		if (commit) begin
			nbr_q    <= res_nbr;
			status_q <= res_status;
			ocnt_q   <= OCNT_W'(cnt_d);
		end
	end

	oul_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (start),
		.step   (state_q == S_SCAN),
		.t      (t_q),
		.cnt    (cnt_q),
		.head   (entry[0]),
		.id     (id_q),
		.res    (scan)
	);

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		localparam int NXT = (i + 1) % MAX_ENTRIES;

		always_comb begin
			ctl[i].rot       = (state_q == S_SCAN);
			ctl[i].take_next = do_rm && (IDX_W'(i) >= scan.pos) && (i < MAX_ENTRIES - 1);
			ctl[i].load      = do_add && (CNT_W'(i) == cnt_q);
		end

		oul_cell u_cell (
			.clk      (clk),
			.ctl      (ctl[i]),
			.nbr      (entry[NXT]),
			.load_val (id_q),
			.entry    (entry[i])
		);
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {7'b0, ocnt_q, status_q, nbr_q};

`ifndef SYNTH
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_ENTRIES))
		else $error("entry count above capacity");
	a_cnt_only_commit: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != $past(cnt_q) |-> $past(state_q) == S_COMMIT)
		else $error("entry count changed outside commit");
	a_scan_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN && t_q == IDX_W'(MAX_ENTRIES - 1) |=> state_q == S_COMMIT)
		else $error("scan did not end after a full rotation");
	a_match_valid: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_COMMIT && scan.found |-> CNT_W'(scan.pos) < cnt_q)
		else $error("match position beyond list");
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		commit && res_status == ST_FULL |-> cnt_q == CNT_W'(MAX_ENTRIES))
		else $error("full reported on a list with room");
`endif

endmodule
